[design/ubhe_pkg.sv]
package ubhe_pkg;

    localparam int NRES  = 5;
    localparam int CNT_W = 3;
    localparam int IDX_W = 3;

    localparam logic [1:0] ACT_CMD  = 2'd0;
    localparam logic [1:0] ACT_RX   = 2'd1;
    localparam logic [1:0] ACT_PAY  = 2'd2;
    localparam logic [1:0] ACT_TICK = 2'd3;

    localparam logic [2:0] CMD_SYNC    = 3'd0;
    localparam logic [2:0] CMD_VERSION = 3'd1;
    localparam logic [2:0] CMD_VPROT   = 3'd2;
    localparam logic [2:0] CMD_ID      = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;
    localparam logic [2:0] CMD_ERASE   = 3'd5;
    localparam logic [2:0] CMD_WRITE   = 3'd6;
    localparam logic [2:0] CMD_GO      = 3'd7;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_REJECT  = 2'd3;

    localparam logic [7:0]  ACK_BYTE  = 8'h79;
    localparam logic [7:0]  SYNC_BYTE = 8'h7f;
    localparam logic [15:0] NO_PAGE   = 16'hffff;
    localparam logic [31:0] TIMEOUT_RESET = 32'd3000000;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  command;
        logic [31:0] address;
        logic [7:0]  count_minus_one;
        logic [15:0] page;
        logic [15:0] erase_count;
        logic [7:0]  byte_value;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0]     cnt;
        res_t [NRES-1:0]      res;
    } burst_t;

    function automatic logic [7:0] opcode_of(input logic [2:0] cmd);
        case (cmd)
            CMD_SYNC:    opcode_of = SYNC_BYTE;
            CMD_VERSION: opcode_of = 8'h00;
            CMD_VPROT:   opcode_of = 8'h01;
            CMD_ID:      opcode_of = 8'h02;
            CMD_READ:    opcode_of = 8'h11;
            CMD_ERASE:   opcode_of = 8'h44;
            CMD_WRITE:   opcode_of = 8'h31;
            default:     opcode_of = 8'h21;
        endcase
    endfunction

    function automatic res_t tx_res(input logic [7:0] b);
        tx_res = '{kind: KIND_TX, out_byte: b, status: ST_DONE};
    endfunction

    function automatic res_t data_res(input logic [7:0] b);
        data_res = '{kind: KIND_DATA, out_byte: b, status: ST_DONE};
    endfunction

    function automatic res_t stat_res(input logic [1:0] s);
        stat_res = '{kind: KIND_STATUS, out_byte: 8'd0, status: s};
    endfunction

endpackage

[design/ubhe_step.sv]
module ubhe_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  ubhe_pkg::item_t     item,
    input  logic [31:0]         timeout_ticks,
    output ubhe_pkg::burst_t    burst
);
    import ubhe_pkg::*;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_WAIT_FINAL = 3'd1;
    localparam logic [2:0] PH_WAIT_ADDR  = 3'd2;
    localparam logic [2:0] PH_AFTER_ADDR = 3'd3;
    localparam logic [2:0] PH_WAIT_ERASE = 3'd4;
    localparam logic [2:0] PH_PAYLOAD    = 3'd5;
    localparam logic [2:0] PH_READ_ACK   = 3'd6;
    localparam logic [2:0] PH_READ_DATA  = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  len_reg, len_next;
    logic [8:0]  idx_reg, idx_next;
    logic [7:0]  xor_reg, xor_next;
    logic [31:0] wait_reg, wait_next;
    logic [15:0] page_reg, page_next;
    logic [15:0] ecnt_reg, ecnt_next;

    logic        waiting;
    logic [8:0]  idx_inc;
    logic        run_done;
    logic [7:0]  op;
    logic [7:0]  pay_xor;

    assign waiting  = (phase_reg != PH_IDLE) && (phase_reg != PH_PAYLOAD);
    assign idx_inc  = idx_reg + 9'd1;
    assign run_done = idx_inc >= ({1'b0, len_reg} + 9'd1);
    assign op       = opcode_of(item.command);
    assign pay_xor  = xor_reg ^ item.byte_value;

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        xor_next   = xor_reg;
        wait_next  = wait_reg;
        page_next  = page_reg;
        ecnt_next  = ecnt_reg;
        burst      = '0;

        if (fire) begin
            case (item.action)
                ACT_CMD: begin
                    if (phase_reg != PH_IDLE) begin
                        burst.res[0] = stat_res(ST_REJECT);
                        burst.cnt    = 3'd1;
                    end else begin
                        cmd_next  = item.command;
                        addr_next = item.address;
                        len_next  = item.count_minus_one;
                        page_next = item.page;
                        ecnt_next = item.erase_count;
                        idx_next  = '0;
                        xor_next  = '0;
                        wait_next = '0;
                        burst.res[0] = tx_res(op);
                        if (item.command == CMD_SYNC) begin
                            burst.cnt = 3'd1;
                        end else begin
                            burst.res[1] = tx_res(~op);
                            burst.cnt    = 3'd2;
                        end
                        case (item.command)
                            CMD_READ, CMD_WRITE, CMD_GO: phase_next = PH_WAIT_ADDR;
                            CMD_ERASE:                   phase_next = PH_WAIT_ERASE;
                            default:                     phase_next = PH_WAIT_FINAL;
                        endcase
                    end
                end
                ACT_RX: begin
                    if (!waiting) begin
                        burst.res[0] = stat_res(ST_REJECT);
                        burst.cnt    = 3'd1;
                    end else if (phase_reg == PH_READ_DATA) begin
                        // read data is forwarded unchecked
                        burst.res[0] = data_res(item.byte_value);
                        idx_next     = idx_inc;
                        if (run_done) begin
                            burst.res[1] = stat_res(ST_DONE);
                            burst.cnt    = 3'd2;
                            phase_next   = PH_IDLE;
                        end else begin
                            burst.cnt = 3'd1;
                        end
                    end else if (item.byte_value != ACK_BYTE) begin
                        burst.res[0] = stat_res(ST_BAD);
                        burst.cnt    = 3'd1;
                        phase_next   = PH_IDLE;
                    end else begin
                        case (phase_reg)
                            PH_WAIT_FINAL: begin
                                burst.res[0] = stat_res(ST_DONE);
                                burst.cnt    = 3'd1;
                                phase_next   = PH_IDLE;
                            end
                            PH_WAIT_ADDR: begin
                                burst.res[0] = tx_res(addr_reg[31:24]);
                                burst.res[1] = tx_res(addr_reg[23:16]);
                                burst.res[2] = tx_res(addr_reg[15:8]);
                                burst.res[3] = tx_res(addr_reg[7:0]);
                                burst.res[4] = tx_res(addr_reg[31:24] ^ addr_reg[23:16]
                                                      ^ addr_reg[15:8] ^ addr_reg[7:0]);
                                burst.cnt    = 3'd5;
                                phase_next   = PH_AFTER_ADDR;
                                wait_next    = '0;
                            end
                            PH_AFTER_ADDR: begin
                                if (cmd_reg == CMD_READ) begin
                                    burst.res[0] = tx_res(len_reg);
                                    burst.res[1] = tx_res(~len_reg);
                                    burst.cnt    = 3'd2;
                                    phase_next   = PH_READ_ACK;
                                    wait_next    = '0;
                                end else if (cmd_reg == CMD_WRITE) begin
                                    burst.res[0] = tx_res(len_reg);
                                    burst.cnt    = 3'd1;
                                    xor_next     = len_reg;
                                    idx_next     = '0;
                                    phase_next   = PH_PAYLOAD;
                                end else begin
                                    burst.res[0] = stat_res(ST_DONE);
                                    burst.cnt    = 3'd1;
                                    phase_next   = PH_IDLE;
                                end
                            end
                            PH_WAIT_ERASE: begin
                                if (page_reg != NO_PAGE) begin
                                    burst.res[0] = tx_res(ecnt_reg[15:8]);
                                    burst.res[1] = tx_res(ecnt_reg[7:0]);
                                    burst.res[2] = tx_res(page_reg[15:8]);
                                    burst.res[3] = tx_res(page_reg[7:0]);
                                    burst.res[4] = tx_res(ecnt_reg[15:8] ^ ecnt_reg[7:0]
                                                          ^ page_reg[15:8] ^ page_reg[7:0]);
                                    burst.cnt    = 3'd5;
                                end
                                phase_next = PH_WAIT_FINAL;
                                wait_next  = '0;
                            end
                            default: begin
                                // ack ahead of read data; timer keeps running
                                idx_next   = '0;
                                phase_next = PH_READ_DATA;
                            end
                        endcase
                    end
                end
                ACT_PAY: begin
                    if (phase_reg != PH_PAYLOAD) begin
                        burst.res[0] = stat_res(ST_REJECT);
                        burst.cnt    = 3'd1;
                    end else begin
                        burst.res[0] = tx_res(item.byte_value);
                        xor_next     = pay_xor;
                        idx_next     = idx_inc;
                        if (run_done) begin
                            burst.res[1] = tx_res(pay_xor);
                            burst.cnt    = 3'd2;
                            phase_next   = PH_WAIT_FINAL;
                            wait_next    = '0;
                        end else begin
                            burst.cnt = 3'd1;
                        end
                    end
                end
                default: begin
                    if (waiting) begin
                        if (wait_reg >= timeout_ticks) begin
                            burst.res[0] = stat_res(ST_TIMEOUT);
                            burst.cnt    = 3'd1;
                            phase_next   = PH_IDLE;
                        end else begin
                            wait_next = wait_reg + 32'd1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= '0;
            addr_reg  <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            xor_reg   <= '0;
            wait_reg  <= '0;
            page_reg  <= '0;
            ecnt_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            addr_reg  <= addr_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            xor_reg   <= xor_next;
            wait_reg  <= wait_next;
            page_reg  <= page_next;
            ecnt_reg  <= ecnt_next;
        end
    end

endmodule

[design/ubhe_outq.sv]
module ubhe_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  ubhe_pkg::burst_t  burst,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast
);
    import ubhe_pkg::*;

    res_t             res_reg [NRES];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             xfer;
    res_t             head;

    assign head     = res_reg[idx_reg];
    assign m_tvalid = cnt_reg != '0;
    assign m_tlast  = {1'b0, idx_reg} == ({1'b0, cnt_reg} - 4'd1);
    assign m_tdata  = {6'd0, head.status, head.out_byte};
    assign m_tuser  = head.kind;
    assign xfer     = m_tvalid && m_tready;
    assign free     = !m_tvalid || (xfer && m_tlast);

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = burst.cnt;
            idx_next = '0;
        end else if (xfer) begin
            if (m_tlast) begin
                cnt_next = '0;
                idx_next = '0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < NRES; i++) begin
                res_reg[i] <= burst.res[i];
            end
        end
    end

endmodule

[design/uart_bootloader_host_engine_core.sv]
// Host side of the serial bootloader exchange. Each transfer in carries an action in
// s_tuser: a command request, a byte received from the link, a write payload byte or a
// timer tick. The engine answers with bytes to transmit, forwarded read data and status
// items on the m_ channel, up to five per input, the last one flagged by m_tlast; a tick
// that does not time out, a read ack and an erase ack with no page give none. An input
// waits in the input register while the output buffer is busy; its results are then
// loaded into the five-entry buffer and drained at one transfer per cycle while m_tready
// is high. Inputs are taken every cycle while each yields at most one result and m_tready
// stays high; one with more results holds the buffer until its last is taken, and one
// further input waits meanwhile. The timeout limit resets to 3000000 ticks; the user must
// write it through cfg_wr_en/cfg_wr_data only while the engine is idle, which is not enforced.
module uart_bootloader_host_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] command, [34:3] address, [42:35] count_minus_one, [58:43] page,
    // [74:59] erase_count, [82:75] byte_value, [87:83] zero
    input  logic [87:0] s_tdata,
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);
    import ubhe_pkg::*;

    logic [31:0] timeout_reg;
    logic        in_valid_reg, in_valid_next;
    item_t       in_reg;
    logic        free;
    logic        fire;
    burst_t      burst;

    assign fire          = in_valid_reg && free;
    assign s_tready      = !in_valid_reg || free;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= TIMEOUT_RESET;
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.action          <= s_tuser;
            in_reg.command         <= s_tdata[2:0];
            in_reg.address         <= s_tdata[34:3];
            in_reg.count_minus_one <= s_tdata[42:35];
            in_reg.page            <= s_tdata[58:43];
            in_reg.erase_count     <= s_tdata[74:59];
            in_reg.byte_value      <= s_tdata[82:75];
        end
    end

    ubhe_step u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .item          (in_reg),
        .timeout_ticks (timeout_reg),
        .burst         (burst)
    );

    ubhe_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .burst    (burst),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[design/ubhe_checker.sv]
module ubhe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import ubhe_pkg::*;

    // stalled output transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output changed while stalled");

    // a status always closes the results of its input
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS |-> m_tlast)
        else $error("status not last");

    a_byte_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_STATUS |-> m_tdata[9:8] == ST_DONE)
        else $error("status field set on byte result");

    a_status_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS |-> m_tdata[7:0] == 8'd0)
        else $error("byte field set on status result");

endmodule

bind uart_bootloader_host_engine_core ubhe_checker u_ubhe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ubhe_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WAIT_FINAL,
        PH_WAIT_ADDR,
        PH_WAIT_AFTER_ADDR,
        PH_WAIT_ERASE,
        PH_PAYLOAD,
        PH_WAIT_READ_ACK,
        PH_READ_DATA
    } host_phase_e;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] st;
        logic       last;
    } link_out_t;

    // a row either carries its one result (or none) typed in, or relies on the engine model
    typedef struct packed {
        item_t     it;
        logic      typed;
        logic      has_res;
        link_out_t res;
    } dir_row_t;

    // opcode per command, command 0 in the low byte
    localparam logic [63:0] OPCODE_TABLE = {8'h21, 8'h31, 8'h44, 8'h11,
                                            8'h02, 8'h01, 8'h00, 8'h7f};
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int N_DIR         = 29;
    localparam int PHASE_ITEMS   = 15;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [2:0] command, [34:3] address, [42:35] count_minus_one, [58:43] page,
    // [74:59] erase_count, [82:75] byte_value, [87:83] zero
    logic [87:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;     // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [7:0] out_byte, [9:8] status, [15:10] zero
    logic [1:0]  m_tuser;          // kind
    logic        m_tlast;

    uart_bootloader_host_engine_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // engine model state
    host_phase_e ph = PH_IDLE;
    logic [2:0]  act_cmd = '0;
    logic [31:0] addr = '0;
    logic [7:0]  len = '0;
    logic [8:0]  idx = '0;
    logic [7:0]  xsum = '0;
    logic [31:0] ticks = '0;
    logic [15:0] pg = '0;
    logic [15:0] ecnt = '0;
    logic [31:0] tmo = TIMEOUT_RESET;

    link_out_t link_out_q[$];
    link_out_t step_res[5];
    int        step_n = 0;
    int        errors = 0;
    int        cycles = 0;
    int        busy_items = 0;
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;
    dir_row_t  dir_tab[N_DIR];

    function automatic void emit(logic [1:0] k, logic [7:0] b, logic [1:0] s);
        step_res[step_n] = '{kind: k, data: b, st: s, last: 1'b0};
        step_n++;
    endfunction

    function automatic void enter(host_phase_e p);
        ph = p;
        ticks = '0;
    endfunction

    function automatic void on_ack();
        logic [7:0] b0, b1, b2, b3;
        case (ph)
            PH_WAIT_FINAL: begin
                emit(KIND_STATUS, 8'd0, ST_DONE);
                ph = PH_IDLE;
            end
            PH_WAIT_ADDR: begin
                {b0, b1, b2, b3} = addr;
                emit(KIND_TX, b0, ST_DONE);
                emit(KIND_TX, b1, ST_DONE);
                emit(KIND_TX, b2, ST_DONE);
                emit(KIND_TX, b3, ST_DONE);
                emit(KIND_TX, b0 ^ b1 ^ b2 ^ b3, ST_DONE);
                enter(PH_WAIT_AFTER_ADDR);
            end
            PH_WAIT_AFTER_ADDR: begin
                if (act_cmd == CMD_READ) begin
                    emit(KIND_TX, len, ST_DONE);
                    emit(KIND_TX, ~len, ST_DONE);
                    enter(PH_WAIT_READ_ACK);
                end else if (act_cmd == CMD_WRITE) begin
                    emit(KIND_TX, len, ST_DONE);
                    xsum = len;
                    idx = '0;
                    ph = PH_PAYLOAD;
                end else begin
                    emit(KIND_STATUS, 8'd0, ST_DONE);
                    ph = PH_IDLE;
                end
            end
            PH_WAIT_ERASE: begin
                if (pg != NO_PAGE) begin
                    {b0, b1, b2, b3} = {ecnt, pg};
                    emit(KIND_TX, b0, ST_DONE);
                    emit(KIND_TX, b1, ST_DONE);
                    emit(KIND_TX, b2, ST_DONE);
                    emit(KIND_TX, b3, ST_DONE);
                    emit(KIND_TX, b0 ^ b1 ^ b2 ^ b3, ST_DONE);
                end
                enter(PH_WAIT_FINAL);
            end
            default: begin
                // ack ahead of read data; the wait counter keeps running
                idx = '0;
                ph = PH_READ_DATA;
            end
        endcase
    endfunction

    function automatic void engine_step(item_t it);
        logic waiting;
        logic [7:0] op;
        step_n = 0;
        waiting = (ph != PH_IDLE) && (ph != PH_PAYLOAD);
        case (it.action)
            ACT_CMD: begin
                if (ph != PH_IDLE) begin
                    emit(KIND_STATUS, 8'd0, ST_REJECT);
                end else begin
                    act_cmd = it.command;
                    addr = it.address;
                    len = it.count_minus_one;
                    pg = it.page;
                    ecnt = it.erase_count;
                    idx = '0;
                    xsum = '0;
                    op = OPCODE_TABLE[{it.command, 3'b000} +: 8];
                    emit(KIND_TX, op, ST_DONE);
                    if (it.command != CMD_SYNC)
                        emit(KIND_TX, ~op, ST_DONE);
                    if (it.command == CMD_READ || it.command == CMD_WRITE ||
                        it.command == CMD_GO)
                        enter(PH_WAIT_ADDR);
                    else if (it.command == CMD_ERASE)
                        enter(PH_WAIT_ERASE);
                    else
                        enter(PH_WAIT_FINAL);
                end
            end
            ACT_RX: begin
                if (!waiting) begin
                    emit(KIND_STATUS, 8'd0, ST_REJECT);
                end else if (ph == PH_READ_DATA) begin
                    emit(KIND_DATA, it.byte_value, ST_DONE);
                    idx = idx + 9'd1;
                    if (idx >= {1'b0, len} + 9'd1) begin
                        emit(KIND_STATUS, 8'd0, ST_DONE);
                        ph = PH_IDLE;
                    end
                end else if (it.byte_value != ACK_BYTE) begin
                    emit(KIND_STATUS, 8'd0, ST_BAD);
                    ph = PH_IDLE;
                end else begin
                    on_ack();
                end
            end
            ACT_PAY: begin
                if (ph != PH_PAYLOAD) begin
                    emit(KIND_STATUS, 8'd0, ST_REJECT);
                end else begin
                    emit(KIND_TX, it.byte_value, ST_DONE);
                    xsum = xsum ^ it.byte_value;
                    idx = idx + 9'd1;
                    if (idx >= {1'b0, len} + 9'd1) begin
                        emit(KIND_TX, xsum, ST_DONE);
                        enter(PH_WAIT_FINAL);
                    end
                end
            end
            default: begin
                if (waiting) begin
                    if (ticks >= tmo) begin
                        emit(KIND_STATUS, 8'd0, ST_TIMEOUT);
                        ph = PH_IDLE;
                    end else begin
                        ticks = ticks + 32'd1;
                    end
                end
            end
        endcase
        if (step_n > 0)
            step_res[step_n - 1].last = 1'b1;
    endfunction

    function automatic item_t mk(logic [1:0] a, logic [2:0] c, logic [31:0] ad,
                                 logic [7:0] n, logic [15:0] p, logic [15:0] e,
                                 logic [7:0] b);
        item_t it;
        it = '{action: a, command: c, address: ad, count_minus_one: n, page: p,
               erase_count: e, byte_value: b};
        return it;
    endfunction

    function automatic item_t rand_item(logic [1:0] a);
        item_t it;
        it.action = a;
        it.command = 3'($urandom_range(7));
        it.address = $urandom;
        it.count_minus_one = 8'($urandom);
        it.page = 16'($urandom);
        it.erase_count = 16'($urandom);
        it.byte_value = 8'($urandom);
        return it;
    endfunction

    function automatic link_out_t lk(logic [1:0] k, logic [1:0] s);
        return '{kind: k, data: 8'd0, st: s, last: 1'b1};
    endfunction

    function automatic dir_row_t row_one(item_t it, link_out_t r);
        return '{it: it, typed: 1'b1, has_res: 1'b1, res: r};
    endfunction

    function automatic dir_row_t row_none(item_t it);
        return '{it: it, typed: 1'b1, has_res: 1'b0, res: '0};
    endfunction

    function automatic dir_row_t row_pred(item_t it);
        return '{it: it, typed: 1'b0, has_res: 1'b0, res: '0};
    endfunction

    // called at a rising edge; returns at the edge where the transfer happened
    task automatic send_item(item_t it, logic typed, logic has_res, link_out_t res);
        if (!calm && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {5'd0, it.byte_value, it.erase_count, it.page, it.count_minus_one,
                     it.address, it.command};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        engine_step(it);
        if (step_n > 0)
            busy_items++;
        if (typed) begin
            if (has_res)
                link_out_q.push_back(res);
        end else begin
            for (int i = 0; i < step_n; i++)
                link_out_q.push_back(step_res[i]);
        end
    endtask

    task automatic send(item_t it);
        send_item(it, 1'b0, 1'b0, '0);
    endtask

    // one exchange, mostly well formed, with ticks, bad replies and stray items mixed in
    task automatic run_exchange(bit pick, logic [2:0] pcmd, logic [7:0] plen);
        item_t it;
        int unsigned r;
        if ($urandom_range(9) == 0)
            send(rand_item(2'($urandom_range(1, 3))));
        it = rand_item(ACT_CMD);
        if ($urandom_range(15) != 0)
            it.count_minus_one = 8'($urandom_range(3));
        if ($urandom_range(3) == 0)
            it.page = NO_PAGE;
        if (pick) begin
            it.command = pcmd;
            it.count_minus_one = plen;
        end
        send(it);
        while (ph != PH_IDLE) begin
            r = $urandom_range(99);
            if (ph == PH_PAYLOAD) begin
                it = rand_item(r < 88 ? ACT_PAY : (r < 94 ? ACT_RX : ACT_TICK));
            end else if (ph == PH_READ_DATA) begin
                it = rand_item(r < 88 ? ACT_RX : (r < 94 ? ACT_TICK : ACT_CMD));
            end else if (r < 72) begin
                it = rand_item(ACT_RX);
                it.byte_value = ACK_BYTE;
            end else if (r < 84) begin
                it = rand_item(ACT_TICK);
            end else if (r < 90) begin
                it = rand_item(ACT_RX);
            end else if (r < 95) begin
                it = rand_item(ACT_PAY);
            end else begin
                it = rand_item(ACT_CMD);
            end
            send(it);
        end
    endtask

    // bring the exchange back to idle and let the engine drain
    task automatic settle();
        item_t it;
        while (ph != PH_IDLE) begin
            it = rand_item(ph == PH_PAYLOAD ? ACT_PAY : ACT_RX);
            if (ph != PH_PAYLOAD && ph != PH_READ_DATA && it.byte_value == ACK_BYTE)
                it.byte_value = 8'h00;
            send(it);
        end
        s_tvalid <= 1'b0;
        while (link_out_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_timeout(logic [31:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tmo = v;
    endtask

    initial begin
        logic [31:0] tsel;
        int start;
        dir_tab[0]  = row_one(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE),
                              lk(KIND_STATUS, ST_REJECT));
        dir_tab[1]  = row_one(mk(ACT_PAY, CMD_SYNC, 0, 0, 0, 0, 8'h5a),
                              lk(KIND_STATUS, ST_REJECT));
        dir_tab[2]  = row_none(mk(ACT_TICK, CMD_SYNC, 0, 0, 0, 0, 0));
        dir_tab[3]  = row_one(mk(ACT_CMD, CMD_SYNC, 0, 0, 0, 0, 0),
                              '{kind: KIND_TX, data: SYNC_BYTE, st: ST_DONE, last: 1'b1});
        dir_tab[4]  = row_one(mk(ACT_CMD, CMD_VERSION, 0, 0, 0, 0, 0),
                              lk(KIND_STATUS, ST_REJECT));
        dir_tab[5]  = row_one(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE),
                              lk(KIND_STATUS, ST_DONE));
        // erase with no page frame
        dir_tab[6]  = row_pred(mk(ACT_CMD, CMD_ERASE, 0, 0, NO_PAGE, 16'h0000, 0));
        dir_tab[7]  = row_pred(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE));
        dir_tab[8]  = row_one(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE),
                              lk(KIND_STATUS, ST_DONE));
        dir_tab[9]  = row_pred(mk(ACT_CMD, CMD_ERASE, 0, 0, 16'h0000, 16'hffff, 0));
        dir_tab[10] = row_pred(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE));
        dir_tab[11] = row_one(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, 8'h00),
                              lk(KIND_STATUS, ST_BAD));
        dir_tab[12] = row_pred(mk(ACT_CMD, CMD_WRITE, 32'hffff_ffff, 8'd0, 0, 0, 0));
        dir_tab[13] = row_pred(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE));
        dir_tab[14] = row_pred(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE));
        // no reply is awaited while the payload is taken
        dir_tab[15] = row_one(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE),
                              lk(KIND_STATUS, ST_REJECT));
        dir_tab[16] = row_pred(mk(ACT_PAY, CMD_SYNC, 0, 0, 0, 0, 8'hff));
        dir_tab[17] = row_one(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, 8'hff),
                              lk(KIND_STATUS, ST_BAD));
        dir_tab[18] = row_pred(mk(ACT_CMD, CMD_READ, 32'h0000_0000, 8'd1, 0, 0, 0));
        dir_tab[19] = row_pred(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE));
        dir_tab[20] = row_pred(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE));
        dir_tab[21] = row_pred(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE));
        dir_tab[22] = row_pred(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE));
        dir_tab[23] = row_pred(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, 8'h86));
        dir_tab[24] = row_pred(mk(ACT_CMD, CMD_VPROT, 0, 0, 0, 0, 0));
        dir_tab[25] = row_one(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, 8'h7a),
                              lk(KIND_STATUS, ST_BAD));
        dir_tab[26] = row_pred(mk(ACT_CMD, CMD_ID, 0, 0, 0, 0, 0));
        dir_tab[27] = row_one(mk(ACT_RX, CMD_SYNC, 0, 0, 0, 0, ACK_BYTE),
                              lk(KIND_STATUS, ST_DONE));
        dir_tab[28] = row_pred(mk(ACT_CMD, CMD_GO, 32'h8000_0001, 0, 0, 0, 0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].has_res, dir_tab[i].res);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       tsel = 32'd0;
                1:       tsel = 32'd1;
                2:       tsel = 32'hffff_ffff;
                3:       tsel = 32'd6;
                default: tsel = 32'($urandom_range(2, 20));
            endcase
            calm = (p == 2);
            set_timeout(tsel);
            if (p == 1)
                hold_req = 1'b1;
            if (p == 2) begin
                run_exchange(1'b1, CMD_WRITE, 8'd7);
                run_exchange(1'b1, CMD_READ, 8'd7);
            end
            start = busy_items;
            while (busy_items - start < PHASE_ITEMS)
                run_exchange(1'b0, CMD_SYNC, 8'd0);
        end
        calm = 1'b0;
        settle();

        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 22);
            end
        end
    end

    always @(posedge aclk) begin
        link_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (link_out_q.size() == 0) begin
                $error("unexpected transfer: kind %0d byte %h status %0d last %0d",
                       m_tuser, m_tdata[7:0], m_tdata[9:8], m_tlast);
                errors++;
            end else begin
                want = link_out_q.pop_front();
                if (m_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[7:0] !== want.data) begin
                    $error("out_byte: expected %h, got %h", want.data, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[9:8] !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, m_tdata[9:8]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
